[rtl/integer_set_table_top_assert.svh]
// Assertion macros shared by the integer set table RTL.
`ifndef INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ist_pkg.sv]
// Shared types and codes of the integer set table.
`default_nettype none

package ist_pkg;

   localparam int unsigned RSP_COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_RESP   = 6'b010000,
      S_SPARE  = 6'b100000
   } state_type;

   // One write port of the element store.
   typedef struct packed {
      logic en;
   } store_ctl_type;

endpackage

`default_nettype wire

[rtl/ist_store.sv]
// Element store: one write port and one registered read port.
`default_nettype none

module ist_store
   import ist_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 4
) (
   input  wire logic             clock,
   input  wire store_ctl_type    wr_ctl,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/integer_set_table_top.sv]
// Integer set table: bounded set of distinct integers with linear search.
//  - Request channel req_*: tuser carries the operation (insert, remove,
//    lookup, clear), tdata the signed 32-bit value. A beat is taken when
//    req_tvalid and req_tready are both high.
//  - Response channel rsp_*: one beat per request with status, present flag
//    and the element count after the request.
//  - The block handles one request at a time; req_tready is high only while
//    the sequencer is idle. A finished response waits in the output register,
//    so the next request is taken while rsp_tready is low, but it cannot
//    finish until that response has been taken.
//  - Steps from request to response: a clear goes straight to the response
//    state; any other request scans the stored entries up to a match (no
//    scan when empty), then decides; a remove that hits shifts any later
//    entries down before the response. The scan reads one entry a cycle
//    through the single store read port; a remove stops at the match and
//    moves each later entry down one place a cycle, so scan and move
//    together cover every stored entry.
//  - Reset empties the set and drops any pending response. Store contents
//    are not cleared; only entries below the fill count are ever used.
//  - A stalled receiver holds the response beat stable until it is taken.
`default_nettype none

`include "integer_set_table_top_assert.svh"

module integer_set_table_top
   import ist_pkg::*;
#(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata    // [1:0] status, [2] present, [7:3] count
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // Sequencer state
   state_type            state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   op_type               op_ff, op_in;
   logic [ELEM_WIDTH-1:0] key_ff, key_in;
   logic                 present_ff, present_in;
   status_type           status_ff, status_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Store ports
   store_ctl_type         wr_ctl;
   logic [AW-1:0]         wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic [ELEM_WIDTH-1:0] rd_data;

   logic [CW-1:0]          idx_plus;
   logic                   hit;
   logic                   req_fire;
   logic                   rsp_slot_free;
   logic [CW+RSP_COUNT_W-1:0] count_wide;

   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;
   assign idx_plus      = CW'(idx_ff) + CW'(1);
   // Shared compare unit: stored entry against the request key
   assign hit           = (rd_data == key_ff);
   assign count_wide    = {{RSP_COUNT_W{1'b0}}, count_ff};

   ist_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      present_in = present_ff;
      status_in  = status_ff;
      wr_ctl.en  = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = key_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = op_type'(req_tuser);
               key_in     = ELEM_WIDTH'($signed(req_tdata));
               present_in = 1'b0;
               status_in  = ST_DONE;
               idx_in     = '0;
               if (op_type'(req_tuser) == OP_CLEAR) begin
                  count_in = '0;
                  state_in = S_RESP;
               end else if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_data holds the entry at idx_ff
            if (hit) begin
               present_in = 1'b1;
               state_in   = S_DECIDE;
            end else if (idx_plus == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (op_ff)
               OP_INSERT: begin
                  if (present_ff) begin
                     status_in = ST_REFUSED;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_ctl.en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (!present_ff) begin
                     status_in = ST_REFUSED;
                  end else if (idx_plus < count_ff) begin
                     idx_in   = idx_ff + AW'(1);
                     state_in = S_SHIFT;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHIFT: begin
            // Move the entry at idx_ff down one place
            wr_ctl.en = 1'b1;
            wr_addr   = idx_ff - AW'(1);
            wr_data   = rd_data;
            if (idx_plus < count_ff) begin
               idx_in = idx_ff + AW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_present_in = present_ff;
               rsp_count_in   = count_wide[RSP_COUNT_W-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      present_ff     <= present_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_present_ff, rsp_status_ff};

   `IST_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `IST_ASSERT_NEXT(a_busy_after_req, req_fire, state_ff != S_IDLE, "idle right after request")
   `IST_ASSERT_NOW(a_rsp_from_resp, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff) == S_RESP, "response without sequencer")
   `IST_ASSERT_NEXT(a_insert_grows, (state_ff == S_DECIDE) && (op_ff == OP_INSERT) && !present_ff && (count_ff < CW'(CAPACITY)), count_ff == $past(count_ff) + CW'(1), "insert lost")

endmodule

`default_nettype wire

[tb/sv/integer_set_checker.sv]
// Checker for the integer set table: shadows the set, predicts each response beat, compares.
`timescale 1ns / 100ps

module integer_set_checker
   import ist_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // [1:0] status, [2] present, [7:3] count
   output int unsigned      failures,
   output int unsigned      outstanding,
   output int unsigned      checked
);

   // Packed in rsp_tdata order: status in the lowest bits.
   typedef struct packed {
      logic [RSP_COUNT_W-1:0] count;
      logic                   present;
      status_type             status;
   } set_outcome_type;

   logic [31:0]     shadow_members [CAPACITY];
   int unsigned     shadow_count;
   set_outcome_type expected_responses [$];
   int unsigned     fail_tally;
   int unsigned     check_tally;

   // Apply one request to the shadow set and return the response it must produce.
   function automatic set_outcome_type apply_set_request(op_type op, logic [31:0] value);
      set_outcome_type outcome;
      int              slot;
      outcome.status  = ST_DONE;
      outcome.present = 1'b0;
      if (op == OP_CLEAR) begin
         shadow_count = 0;
      end else begin
         slot = -1;
         for (int i = 0; i < shadow_count; i++)
            if (slot < 0 && shadow_members[i] == value) slot = i;
         outcome.present = (slot >= 0);
         case (op)
            OP_INSERT: begin
               if (outcome.present) outcome.status = ST_REFUSED;
               else if (shadow_count >= CAPACITY) outcome.status = ST_FULL;
               else begin
                  shadow_members[shadow_count] = value;
                  shadow_count++;
               end
            end
            OP_REMOVE: begin
               if (!outcome.present) outcome.status = ST_REFUSED;
               else begin
                  // close the gap, keep insertion order
                  for (int i = slot; i + 1 < shadow_count; i++)
                     shadow_members[i] = shadow_members[i + 1];
                  shadow_count--;
               end
            end
            default: ;
         endcase
      end
      outcome.count = shadow_count[RSP_COUNT_W-1:0];
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      set_outcome_type want;
      set_outcome_type got;
      if (reset) begin
         shadow_count = 0;
         expected_responses.delete();
      end else begin
         // A response can never belong to a request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = set_outcome_type'(rsp_tdata);
            if (expected_responses.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("%0t: unexpected response beat: status %0d present %0d count %0d",
                           $realtime, got.status, got.present, got.count);
            end else begin
               want = expected_responses.pop_front();
               check_tally++;
               if (got.status !== want.status || got.present !== want.present ||
                   got.count !== want.count) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display({"%0t: mismatch: expected status %0d present %0d count %0d,",
                               " got status %0d present %0d count %0d"},
                              $realtime, want.status, want.present, want.count,
                              got.status, got.present, got.count);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_responses.push_back(apply_set_request(op_type'(req_tuser), req_tdata));
      end
      outstanding <= expected_responses.size();
      failures    <= fail_tally;
      checked     <= check_tally;
   end

endmodule

[tb/sv/testbench.sv]
// Top of the integer set table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import ist_pkg::*;

   localparam int unsigned CAPACITY     = 16;
   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned POOL_SIZE    = 24;
   // Allow ample margin over the slowest request with a full table and for
   // stalls on the response side.
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned SETTLE       = 50;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;      // [31:0] value
   logic [1:0]  req_tuser  = OP_LOOKUP; // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [1:0] status, [2] present, [7:3] count

   int unsigned failures;
   int unsigned outstanding;
   int unsigned checked;

   bit          idling_on = 1'b1;
   int unsigned quiet_cycles = 0;
   int unsigned op_tally [4];
   logic [31:0] value_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_set_table_top #(
      .CAPACITY  (CAPACITY),
      .ELEM_WIDTH(32)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   integer_set_checker #(
      .CAPACITY(CAPACITY)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .outstanding(outstanding),
      .checked    (checked)
   );

   // Stall the response side with a probability of one in five, unless idling is off.
   always @(posedge clock) begin
      rsp_tready <= idling_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
   end

   // End the run once nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired, no beat in %0d cycles", $realtime, QUIET_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request beat and hold it until the block takes it.
   // Valid stays high between back-to-back beats; drop it only for a gap.
   task automatic issue_request(op_type op, logic [31:0] value);
      while (idling_on && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      op_tally[op]++;
   endtask

   initial begin : stimulus
      logic [31:0] last_fill;
      logic [31:0] value;
      op_type      op;
      int unsigned pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty set, extremes of the value, duplicates, a
      // removal from the middle, a full table, removal at both ends, clear.
      issue_request(OP_LOOKUP, 32'h0000_0000);  // lookup in an empty set
      issue_request(OP_REMOVE, 32'hFFFF_FFFF);  // remove from an empty set
      issue_request(OP_INSERT, 32'h8000_0000);
      issue_request(OP_INSERT, 32'h7FFF_FFFF);
      issue_request(OP_INSERT, 32'h0000_0000);
      issue_request(OP_INSERT, 32'hFFFF_FFFF);
      issue_request(OP_INSERT, 32'h7FFF_FFFF);  // already present
      issue_request(OP_LOOKUP, 32'h8000_0000);
      issue_request(OP_REMOVE, 32'h0000_0000);  // middle entry, shift down
      issue_request(OP_LOOKUP, 32'h0000_0000);
      last_fill = '0;
      for (int i = 0; i < CAPACITY - 3; i++) begin
         last_fill = $urandom();
         issue_request(OP_INSERT, last_fill);
      end
      issue_request(OP_INSERT, 32'h0000_0001);  // absent value, table full
      issue_request(OP_INSERT, 32'h7FFF_FFFF);  // present value, table full
      issue_request(OP_REMOVE, last_fill);      // last entry, nothing to shift
      issue_request(OP_REMOVE, 32'h8000_0000);  // first entry, longest shift
      issue_request(OP_CLEAR,  32'hFFFF_FFFF);
      issue_request(OP_LOOKUP, 32'h7FFF_FFFF);

      // Random part: values mostly from a small pool so that hits, refusals
      // and a full table come up often; the pool holds the extremes too.
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold a long stretch with no idling on either side
         if (n == 300) idling_on <= 1'b0;
         if (n == 500) idling_on <= 1'b1;
         // refresh the pool now and then, leaving the extremes in place
         if ($urandom_range(0, 99) < 3)
            value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom();

         pick = $urandom_range(0, 99);
         if (pick < 50)      op = OP_INSERT;
         else if (pick < 75) op = OP_REMOVE;
         else if (pick < 99) op = OP_LOOKUP;
         else                op = OP_CLEAR;

         if ($urandom_range(0, 99) < 15) value = $urandom();
         else value = value_pool[$urandom_range(0, POOL_SIZE - 1)];

         issue_request(op, value);
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every expected response, then let the block settle.
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d requests: %0d insert, %0d remove, %0d lookup, %0d clear,",
               op_tally[OP_INSERT] + op_tally[OP_REMOVE] + op_tally[OP_LOOKUP] +
               op_tally[OP_CLEAR], op_tally[OP_INSERT], op_tally[OP_REMOVE],
               op_tally[OP_LOOKUP], op_tally[OP_CLEAR]);
      $display("with %0d response beats checked against the shadow set.", checked);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_store.sv
rtl/integer_set_table_top.sv
tb/sv/integer_set_checker.sv
tb/sv/testbench.sv
